// ===== hw/rtl/mcspg_pkg.sv =====
package mcspg_pkg;

  // number of servo channels kept in the core
  localparam int CHANNELS = 8;
  // channels that reach the pins field
  localparam int PIN_W = 8;
  localparam int VISIBLE = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

  localparam int WIDTH_W = 16;
  localparam int CHAN_W = 3;
  localparam logic [WIDTH_W-1:0] FRAME_LENGTH_RESET = 16'd3125;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_SET  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [CHAN_W-1:0]   channel;
    logic [WIDTH_W-1:0]  width;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0] pins;
    logic             frame_start;
  } result_t;

endpackage

// ===== hw/rtl/mcspg_in_stage.sv =====
module mcspg_in_stage
  import mcspg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hw/rtl/mcspg_core.sv =====
module mcspg_core
  import mcspg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [WIDTH_W-1:0] cfg_data,
  input  logic               proc,
  input  item_t              item,
  output result_t            result
);

  logic [WIDTH_W-1:0]  len_r;
  logic [WIDTH_W-1:0]  cnt_r, cnt_nxt;
  logic [WIDTH_W-1:0]  aw_r [CHANNELS];
  logic [WIDTH_W-1:0]  aw_nxt [CHANNELS];
  logic [WIDTH_W-1:0]  pw_r [CHANNELS];
  logic [CHANNELS-1:0] pv_r, pv_nxt;
  logic [CHANNELS-1:0] hit;
  logic [PIN_W-1:0]    held_r, held_nxt;
  logic [PIN_W-1:0]    levels;
  logic [WIDTH_W-1:0]  len;
  logic [WIDTH_W:0]    cnt_inc;
  logic                start;
  logic                tick;
  logic                upd;

  // zero length behaves as one tick per frame
  assign len     = (len_r == '0) ? {{(WIDTH_W-1){1'b0}}, 1'b1} : len_r;
  assign start   = (cnt_r == '0);
  assign tick    = proc && (item.mode == MODE_TICK);
  assign upd     = proc && (item.mode == MODE_SET);
  assign cnt_inc = {1'b0, cnt_r} + {{WIDTH_W{1'b0}}, 1'b1};

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      aw_nxt[k] = aw_r[k];
      if (start && pv_r[k]) begin
        aw_nxt[k] = (pw_r[k] > len) ? len : pw_r[k];
      end
      hit[k] = (aw_nxt[k] != '0) && (cnt_r < aw_nxt[k]);
    end
    levels = '0;
    for (int k = 0; k < VISIBLE; k++) begin
      levels[k] = hit[k];
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    pv_nxt   = pv_r;
    held_nxt = held_r;
    result.pins        = held_r;
    result.frame_start = 1'b0;
    if (tick) begin
      cnt_nxt  = (cnt_inc >= {1'b0, len}) ? '0 : cnt_inc[WIDTH_W-1:0];
      held_nxt = levels;
      if (start) begin
        pv_nxt = '0;
      end
      result.pins        = levels;
      result.frame_start = start;
    end
    if (upd) begin
      for (int k = 0; k < CHANNELS; k++) begin
        if (32'(item.channel) == 32'(k)) begin
          pv_nxt[k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= FRAME_LENGTH_RESET;
      cnt_r  <= '0;
      pv_r   <= '0;
      held_r <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        aw_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        len_r <= cfg_data;
      end
      cnt_r  <= cnt_nxt;
      pv_r   <= pv_nxt;
      held_r <= held_nxt;
      if (tick) begin
        for (int k = 0; k < CHANNELS; k++) begin
          aw_r[k] <= aw_nxt[k];
        end
      end
    end
  end

  // pending widths are gated by their valid bits, no reset needed
  always_ff @(posedge clk) begin
    for (int k = 0; k < CHANNELS; k++) begin
      if (upd && (32'(item.channel) == 32'(k))) begin
        pw_r[k] <= item.width;
      end
    end
  end

  a_start_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    tick && start |=> pv_r == '0)
    else $error("pending widths not taken at frame start");

  a_update_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> $stable(cnt_r))
    else $error("width update moved the frame counter");

  a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (cnt_r == '0) || (cnt_r == $past(cnt_r) + 16'd1))
    else $error("frame counter skipped");

endmodule

// ===== hw/rtl/mcspg_out_reg.sv =====
module mcspg_out_reg
  import mcspg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== hw/rtl/multi_channel_servo_pulse_generator_core.sv =====
// servo pulse generator: tick and width-update requests in, one result request out each
// an accepted request passes the input register and then the result register before its result is valid
// throughput: one request per cycle unless out_tready stalls, set by the single pass of per-channel compares
// reset (rst_n low, synchronous): frame length 3125, counter, active widths, pending flags
// and held pins cleared, both stages empty
module multi_channel_servo_pulse_generator_core
  import mcspg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration: frame_length
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [15:0] cfg_tdata,    // [15:0] frame_length
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // [2:0] channel, [18:3] width, [23:19] zero
  input  logic        in_tuser,     // [0] mode
  // result requests
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] pins
  output logic        out_tuser     // [0] frame_start
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t core_result;
  result_t out_result;

  // the user must make register writes land only while idle; the block does not enforce it and is always ready
  assign cfg_tready = 1'b1;

  // unpack the request; upper padding bits are ignored
  assign in_item.mode    = mode_t'(in_tuser);
  assign in_item.channel = in_tdata[2:0];
  assign in_item.width   = in_tdata[18:3];

  // a held request moves on when the result slot is empty or draining
  assign advance = s1_valid && (!out_tvalid || out_tready);

  mcspg_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // frame counter, active/pending widths and pin compare
  mcspg_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_tvalid && cfg_tready),
    .cfg_data (cfg_tdata),
    .proc     (advance),
    .item     (s1_item),
    .result   (core_result)
  );

  mcspg_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (core_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = out_result.pins;
  assign out_tuser = out_result.frame_start;

endmodule
